/* hdl/swipe_gesture_recognizer_assert.svh */
// assertion macros for the swipe gesture recogniser
`ifndef SWIPE_GESTURE_RECOGNIZER_ASSERT_SVH
`define SWIPE_GESTURE_RECOGNIZER_ASSERT_SVH

// same-cycle implication
`define SGR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SGR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/sgr_pkg.sv */
package sgr_pkg;

   localparam int COORD_BITS_DEF   = 16;
   localparam int CORDIC_STEPS_DEF = 16;

   localparam int FRAC_BITS    = 20;
   localparam int ANG_BITS     = FRAC_BITS + 10;
   localparam int ATAN_LEN     = 24;
   localparam int TAB_IDX_BITS = 5;
   localparam int DEG_BITS     = 11;

   localparam int FUNC_BITS   = 2;
   localparam int CODE_BITS   = 2;
   localparam int DIR_BITS    = 3;
   localparam int ANGLE_BITS  = 9;
   localparam int MIN_DIST_BITS = 8;
   localparam int TOL_BITS    = 6;
   localparam int CSR_IDX_BITS = 1;
   localparam int CSR_DATA_BITS = 8;

   typedef logic [FUNC_BITS-1:0] func_type;
   typedef logic [CODE_BITS-1:0] code_type;
   typedef logic [DIR_BITS-1:0]  dir_type;

   localparam func_type FUNC_PRESS   = 2'd0;
   localparam func_type FUNC_MOVE    = 2'd1;
   localparam func_type FUNC_RELEASE = 2'd2;

   localparam code_type CODE_IGNORE = 2'd0;
   localparam code_type CODE_MAYBE  = 2'd1;
   localparam code_type CODE_CANCEL = 2'd2;
   localparam code_type CODE_FINISH = 2'd3;

   localparam dir_type DIR_NONE  = 3'd0;
   localparam dir_type DIR_RIGHT = 3'd1;
   localparam dir_type DIR_LEFT  = 3'd2;
   localparam dir_type DIR_DOWN  = 3'd3;
   localparam dir_type DIR_UP    = 3'd4;

   localparam logic [CSR_IDX_BITS-1:0] REG_MIN_DISTANCE = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_DIR_TOL      = 1'd1;

   localparam logic [MIN_DIST_BITS-1:0] MIN_DISTANCE_RST = 8'd10;
   localparam logic [TOL_BITS-1:0]      DIR_TOL_RST      = 6'd20;

   localparam logic signed [ANG_BITS-1:0] ANG_45  = ANG_BITS'(45 <<< FRAC_BITS);
   localparam logic signed [ANG_BITS-1:0] ANG_TOP = ANG_BITS'((45 <<< FRAC_BITS) - 1);
   localparam logic signed [ANG_BITS-1:0] ANG_90  = ANG_BITS'(90 <<< FRAC_BITS);
   localparam logic signed [ANG_BITS-1:0] ANG_180 = ANG_BITS'(180 <<< FRAC_BITS);
   localparam logic signed [ANG_BITS-1:0] ANG_360 = ANG_BITS'(360 <<< FRAC_BITS);

   localparam logic signed [DEG_BITS-1:0] DEG_90  = 11'sd90;
   localparam logic signed [DEG_BITS-1:0] DEG_180 = 11'sd180;
   localparam logic signed [DEG_BITS-1:0] DEG_270 = 11'sd270;
   localparam logic signed [DEG_BITS-1:0] DEG_360 = 11'sd360;

   // atan(2^-i) in degrees, 20 fraction bits
   localparam logic [ANG_BITS-1:0] ATAN_TAB [ATAN_LEN] = '{
      30'd47185920, 30'd27855475, 30'd14718068, 30'd7471121, 30'd3750058, 30'd1876857,
      30'd938658, 30'd469357, 30'd234682, 30'd117342, 30'd58671, 30'd29335,
      30'd14668, 30'd7334, 30'd3667, 30'd1833, 30'd917, 30'd458,
      30'd229, 30'd115, 30'd57, 30'd29, 30'd14, 30'd7
   };

endpackage

/* hdl/sgr_req_if.sv */
interface sgr_req_if
   import sgr_pkg::*;
   #(parameter int COORD_BITS = COORD_BITS_DEF)
   ();
   logic                         valid;
   logic                         ready;
   func_type                     func;
   logic signed [COORD_BITS-1:0] pos_x;
   logic signed [COORD_BITS-1:0] pos_y;

   modport source (output valid, func, pos_x, pos_y, input ready);
   modport sink (input valid, func, pos_x, pos_y, output ready);
endinterface

/* hdl/sgr_rsp_if.sv */
interface sgr_rsp_if
   import sgr_pkg::*;
   #(parameter int COORD_BITS = COORD_BITS_DEF)
   ();
   logic                         valid;
   logic                         ready;
   code_type                     result_code;
   dir_type                      swipe_dir;
   logic [ANGLE_BITS-1:0]        angle_deg;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;
   logic                         vert_script_req;
   logic                         horiz_script_req;

   modport source (output valid, result_code, swipe_dir, angle_deg, end_x, end_y,
                   vert_script_req, horiz_script_req, input ready);
   modport sink (input valid, result_code, swipe_dir, angle_deg, end_x, end_y,
                 vert_script_req, horiz_script_req, output ready);
endinterface

/* hdl/swipe_gesture_recognizer.sv */
// channel   direction  handshake          payload
// req_bus   in         valid / ready      func, pos_x, pos_y
// rsp_bus   out        valid / ready      result_code, swipe_dir, angle_deg, end_x, end_y,
//                                         vert_script_req, horiz_script_req
// csr_*     in         csr_we             csr_index, csr_wdata
//
// press, release, ignored moves: the DELTA and PREP states register the result after the request is taken
// a scrolling move: DELTA, PREP, the ITER steps, UNFOLD and CLASS, one vectoring step per cycle in a shared
//   add/sub and barrel shift unit; folded octant edges skip the iterations
// one request at a time: req ready only when idle with the result register empty
// reset is synchronous, active high; clears control state and csr registers
`include "swipe_gesture_recognizer_assert.svh"

module swipe_gesture_recognizer
   import sgr_pkg::*;
   #(
   parameter int COORD_BITS   = COORD_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
   )
   (
   input  logic                      clock,
   input  logic                      reset,
   sgr_req_if.sink                   req_bus,
   sgr_rsp_if.source                 rsp_bus,
   input  logic                      csr_we,
   input  logic [CSR_IDX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
   );

   localparam int CW        = COORD_BITS + FRAC_BITS + 3;
   localparam int STEP_BITS = $clog2(CORDIC_STEPS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DELTA  = 3'd1;
   localparam logic [2:0] ST_PREP   = 3'd2;
   localparam logic [2:0] ST_ITER   = 3'd3;
   localparam logic [2:0] ST_UNFOLD = 3'd4;
   localparam logic [2:0] ST_CLASS  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic button_down_ff, button_down_in;
   logic [MIN_DIST_BITS-1:0] min_distance_ff;
   logic [TOL_BITS-1:0] dir_tol_ff;

   func_type func_ff, func_in;
   logic signed [COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [COORD_BITS-1:0] press_x_ff, press_x_in, press_y_ff, press_y_in;
   logic signed [COORD_BITS-1:0] anchor_x_ff, anchor_x_in, anchor_y_ff, anchor_y_in;
   logic signed [COORD_BITS:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ANG_BITS-1:0] z_ff, z_in;
   logic special_ff, special_in, swap_ff, swap_in, uxneg_ff, uxneg_in, uyneg_ff, uyneg_in;
   logic [ANGLE_BITS-1:0] deg_ff, deg_in;

   code_type code_ff, code_in;
   dir_type dir_ff, dir_in;
   logic [ANGLE_BITS-1:0] angle_ff, angle_in;
   logic signed [COORD_BITS-1:0] end_x_ff, end_x_in, end_y_ff, end_y_in;
   logic vert_ff, vert_in, horiz_ff, horiz_in;

   logic req_take;
   logic signed [COORD_BITS-1:0] ref_x, ref_y;
   logic signed [COORD_BITS:0] neg_dx, neg_dy;
   logic [COORD_BITS-1:0] mag_dx, mag_dy, mag_a, mag_b, md_ext;
   logic passes, swap;
   logic signed [CW-1:0] sh_x, sh_y;
   logic signed [ANG_BITS-1:0] tab_val, oct, t_val, ang;
   logic signed [DEG_BITS-1:0] ang_s, tol_s;
   dir_type sector;

   assign req_bus.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_take      = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.result_code      = code_ff;
   assign rsp_bus.swipe_dir        = dir_ff;
   assign rsp_bus.angle_deg        = angle_ff;
   assign rsp_bus.end_x            = end_x_ff;
   assign rsp_bus.end_y            = end_y_ff;
   assign rsp_bus.vert_script_req  = vert_ff;
   assign rsp_bus.horiz_script_req = horiz_ff;

   // delta and threshold
   assign ref_x  = (func_ff == FUNC_RELEASE) ? press_x_ff : anchor_x_ff;
   assign ref_y  = (func_ff == FUNC_RELEASE) ? press_y_ff : anchor_y_ff;
   assign neg_dx = -dx_ff;
   assign neg_dy = -dy_ff;
   assign mag_dx = dx_ff[COORD_BITS] ? neg_dx[COORD_BITS-1:0] : dx_ff[COORD_BITS-1:0];
   assign mag_dy = dy_ff[COORD_BITS] ? neg_dy[COORD_BITS-1:0] : dy_ff[COORD_BITS-1:0];
   assign md_ext = COORD_BITS'(min_distance_ff);
   assign passes = !((mag_dx < md_ext) && (mag_dy < md_ext));
   assign swap   = mag_dy > mag_dx;
   assign mag_a  = swap ? mag_dy : mag_dx;
   assign mag_b  = swap ? mag_dx : mag_dy;

   // shared cordic step unit
   assign sh_x    = x_ff >>> step_ff;
   assign sh_y    = y_ff >>> step_ff;
   assign tab_val = ATAN_TAB[TAB_IDX_BITS'(step_ff)];

   // unfold octant
   always_comb begin
      if (special_ff) begin
         oct = z_ff;
      end else if (z_ff[ANG_BITS-1] || (z_ff == '0)) begin
         oct = ANG_BITS'(1);
      end else if (z_ff > ANG_TOP) begin
         oct = ANG_TOP;
      end else begin
         oct = z_ff;
      end
      t_val = swap_ff ? (ANG_90 - oct) : oct;
      case ({uxneg_ff, uyneg_ff})
         2'b00:   ang = t_val;
         2'b10:   ang = ANG_180 - t_val;
         2'b11:   ang = ANG_180 + t_val;
         default: ang = ANG_360 - t_val;
      endcase
   end

   // sector decision
   always_comb begin
      ang_s = $signed({2'b00, deg_ff});
      tol_s = $signed({5'b00000, dir_tol_ff});
      if ((ang_s > (DEG_360 - tol_s)) || (ang_s < tol_s)) begin
         sector = DIR_RIGHT;
      end else if ((ang_s < (DEG_180 + tol_s)) && (ang_s > (DEG_180 - tol_s))) begin
         sector = DIR_LEFT;
      end else if ((ang_s > (DEG_270 - tol_s)) && (ang_s < (DEG_270 + tol_s))) begin
         sector = DIR_DOWN;
      end else if ((ang_s > (DEG_90 - tol_s)) && (ang_s < (DEG_90 + tol_s))) begin
         sector = DIR_UP;
      end else begin
         sector = DIR_NONE;
      end
   end

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      rsp_valid_in   = rsp_valid_ff;
      button_down_in = button_down_ff;
      func_in        = func_ff;
      px_in          = px_ff;
      py_in          = py_ff;
      press_x_in     = press_x_ff;
      press_y_in     = press_y_ff;
      anchor_x_in    = anchor_x_ff;
      anchor_y_in    = anchor_y_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      z_in           = z_ff;
      special_in     = special_ff;
      swap_in        = swap_ff;
      uxneg_in       = uxneg_ff;
      uyneg_in       = uyneg_ff;
      deg_in         = deg_ff;
      code_in        = code_ff;
      dir_in         = dir_ff;
      angle_in       = angle_ff;
      end_x_in       = end_x_ff;
      end_y_in       = end_y_ff;
      vert_in        = vert_ff;
      horiz_in       = horiz_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               func_in  = req_bus.func;
               px_in    = req_bus.pos_x;
               py_in    = req_bus.pos_y;
               state_in = ST_DELTA;
            end
         end
         ST_DELTA: begin
            dx_in    = $signed({px_ff[COORD_BITS-1], px_ff}) -
                       $signed({ref_x[COORD_BITS-1], ref_x});
            dy_in    = $signed({py_ff[COORD_BITS-1], py_ff}) -
                       $signed({ref_y[COORD_BITS-1], ref_y});
            state_in = ST_PREP;
         end
         ST_PREP: begin
            code_in  = CODE_IGNORE;
            dir_in   = DIR_NONE;
            angle_in = '0;
            end_x_in = '0;
            end_y_in = '0;
            vert_in  = 1'b0;
            horiz_in = 1'b0;
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
            case (func_ff)
               FUNC_PRESS: begin
                  button_down_in = 1'b1;
                  press_x_in  = px_ff;
                  press_y_in  = py_ff;
                  anchor_x_in = px_ff;
                  anchor_y_in = py_ff;
                  code_in     = CODE_MAYBE;
                  vert_in     = 1'b1;
               end
               FUNC_MOVE: begin
                  if (button_down_ff && passes) begin
                     rsp_valid_in = rsp_valid_ff;
                     anchor_x_in  = px_ff;
                     anchor_y_in  = py_ff;
                     swap_in      = swap;
                     uxneg_in     = dx_ff[COORD_BITS];
                     uyneg_in     = !dy_ff[COORD_BITS] && (dy_ff != '0);
                     x_in         = CW'({mag_a, {FRAC_BITS{1'b0}}});
                     y_in         = CW'({mag_b, {FRAC_BITS{1'b0}}});
                     step_in      = '0;
                     if (mag_b == '0) begin
                        z_in       = '0;
                        special_in = 1'b1;
                        state_in   = ST_UNFOLD;
                     end else if (mag_b == mag_a) begin
                        z_in       = ANG_45;
                        special_in = 1'b1;
                        state_in   = ST_UNFOLD;
                     end else begin
                        z_in       = '0;
                        special_in = 1'b0;
                        state_in   = ST_ITER;
                     end
                  end
               end
               FUNC_RELEASE: begin
                  button_down_in = 1'b0;
                  anchor_x_in    = press_x_ff;
                  anchor_y_in    = press_y_ff;
                  code_in        = passes ? CODE_FINISH : CODE_CANCEL;
               end
               default: begin
               end
            endcase
         end
         ST_ITER: begin
            if (!y_ff[CW-1]) begin
               x_in = x_ff + sh_y;
               y_in = y_ff - sh_x;
               z_in = z_ff + tab_val;
            end else begin
               x_in = x_ff - sh_y;
               y_in = y_ff + sh_x;
               z_in = z_ff - tab_val;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(CORDIC_STEPS - 1)) begin
               state_in = ST_UNFOLD;
            end
         end
         ST_UNFOLD: begin
            deg_in   = ang[FRAC_BITS +: ANGLE_BITS];
            state_in = ST_CLASS;
         end
         ST_CLASS: begin
            code_in      = CODE_IGNORE;
            dir_in       = sector;
            angle_in     = deg_ff;
            end_x_in     = px_ff;
            end_y_in     = py_ff;
            vert_in      = 1'b0;
            horiz_in     = (sector == DIR_RIGHT) || (sector == DIR_LEFT);
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         button_down_ff <= 1'b0;
         press_x_ff     <= '0;
         press_y_ff     <= '0;
         anchor_x_ff    <= '0;
         anchor_y_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         rsp_valid_ff   <= rsp_valid_in;
         button_down_ff <= button_down_in;
         press_x_ff     <= press_x_in;
         press_y_ff     <= press_y_in;
         anchor_x_ff    <= anchor_x_in;
         anchor_y_ff    <= anchor_y_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      special_ff <= special_in;
      swap_ff    <= swap_in;
      uxneg_ff   <= uxneg_in;
      uyneg_ff   <= uyneg_in;
      deg_ff     <= deg_in;
      code_ff    <= code_in;
      dir_ff     <= dir_in;
      angle_ff   <= angle_in;
      end_x_ff   <= end_x_in;
      end_y_ff   <= end_y_in;
      vert_ff    <= vert_in;
      horiz_ff   <= horiz_in;
   end

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_distance_ff <= MIN_DISTANCE_RST;
         dir_tol_ff      <= DIR_TOL_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_MIN_DISTANCE: min_distance_ff <= csr_wdata;
            REG_DIR_TOL:      dir_tol_ff      <= csr_wdata[TOL_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   `SGR_ASSERT_NXT(a_busy_after_req, clock, reset, req_take, !req_bus.ready, "ready after request")
   `SGR_ASSERT_IMP(a_rsp_only_idle, clock, reset, rsp_valid_ff, state_ff == ST_IDLE, "result while busy")
   `SGR_ASSERT_IMP(a_step_range, clock, reset, state_ff == ST_ITER, step_ff <= STEP_BITS'(CORDIC_STEPS - 1), "step overrun")
   `SGR_ASSERT_IMP(a_maybe_vert, clock, reset, rsp_valid_ff && (code_ff == CODE_MAYBE), vert_ff, "press without vertical request")
   `SGR_ASSERT_IMP(a_horiz_dir, clock, reset, rsp_valid_ff && horiz_ff, (dir_ff == DIR_RIGHT) || (dir_ff == DIR_LEFT), "horizontal request without horizontal swipe")

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
   import sgr_pkg::*;

   localparam int CW             = COORD_BITS_DEF;
   localparam int IDLE_LIMIT     = 4000;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = CORDIC_STEPS_DEF + 8;
   localparam func_type FUNC_SPARE = 2'd3;

   typedef struct packed {
      code_type              code;
      dir_type               dir;
      logic [ANGLE_BITS-1:0] angle;
      logic [CW-1:0]         end_x;
      logic [CW-1:0]         end_y;
      logic                  vert_req;
      logic                  horiz_req;
   } swipe_result_type;

   class gesture_scoreboard;
      int unsigned      min_dist;
      int unsigned      tolerance;
      bit               pressed;
      longint           press_x, press_y, anchor_x, anchor_y;
      swipe_result_type expected_results[$];
      int unsigned      errors;

      function new();
         min_dist  = MIN_DISTANCE_RST;
         tolerance = DIR_TOL_RST;
         pressed   = 1'b0;
         press_x   = 0;
         press_y   = 0;
         anchor_x  = 0;
         anchor_y  = 0;
         errors    = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         if (idx == REG_MIN_DISTANCE) begin
            min_dist = data;
         end else if (idx == REG_DIR_TOL) begin
            tolerance = data[TOL_BITS-1:0];
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function bit beyond_click(longint dx, longint dy);
         longint md;
         md = min_dist;
         return !(((dx < 0) ? -dx : dx) < md && ((dy < 0) ? -dy : dy) < md);
      endfunction

      // residual angle of (a, b) with a >= b >= 0, degrees with fraction bits
      function longint octant_residual(longint a, longint b);
         longint x, y, z, xn;
         if (b == 0) return 0;
         if (b == a) return longint'(ANG_45);
         x = a <<< FRAC_BITS;
         y = b <<< FRAC_BITS;
         z = 0;
         for (int i = 0; i < CORDIC_STEPS_DEF && i < ATAN_LEN; i++) begin
            if (y >= 0) begin
               xn = x + (y >>> i);
               y  = y - (x >>> i);
               z  = z + longint'(ATAN_TAB[i]);
            end else begin
               xn = x - (y >>> i);
               y  = y + (x >>> i);
               z  = z - longint'(ATAN_TAB[i]);
            end
            x = xn;
         end
         if (z < 1) z = 1;
         if (z > longint'(ANG_TOP)) z = longint'(ANG_TOP);
         return z;
      endfunction

      // screen y grows downward, so the angle is taken on (dx, -dy)
      function int swipe_angle(longint dx, longint dy);
         longint ux, uy, ax, ay, t, ang;
         ux = dx;
         uy = -dy;
         ax = (ux < 0) ? -ux : ux;
         ay = (uy < 0) ? -uy : uy;
         if (ay <= ax) t = octant_residual(ax, ay);
         else t = longint'(ANG_90) - octant_residual(ay, ax);
         if (ux >= 0 && uy >= 0) ang = t;
         else if (ux < 0 && uy >= 0) ang = longint'(ANG_180) - t;
         else if (ux < 0) ang = longint'(ANG_180) + t;
         else ang = longint'(ANG_360) - t;
         return int'(ang >>> FRAC_BITS);
      endfunction

      function dir_type classify(int ang);
         int tol;
         tol = tolerance;
         if (ang > int'(DEG_360) - tol || ang < tol) return DIR_RIGHT;
         if (ang < int'(DEG_180) + tol && ang > int'(DEG_180) - tol) return DIR_LEFT;
         if (ang > int'(DEG_270) - tol && ang < int'(DEG_270) + tol) return DIR_DOWN;
         if (ang > int'(DEG_90) - tol && ang < int'(DEG_90) + tol) return DIR_UP;
         return DIR_NONE;
      endfunction

      function void note_request(func_type kind, logic [CW-1:0] x_raw, logic [CW-1:0] y_raw);
         swipe_result_type res;
         longint x, y, dx, dy;
         int ang;
         res = '0;
         x = longint'($signed(x_raw));
         y = longint'($signed(y_raw));
         case (kind)
            FUNC_PRESS: begin
               pressed  = 1'b1;
               press_x  = x;
               press_y  = y;
               anchor_x = x;
               anchor_y = y;
               res.code     = CODE_MAYBE;
               res.vert_req = 1'b1;
            end
            FUNC_MOVE: begin
               dx = x - anchor_x;
               dy = y - anchor_y;
               if (pressed && beyond_click(dx, dy)) begin
                  ang = swipe_angle(dx, dy);
                  res.code      = CODE_IGNORE;
                  res.dir       = classify(ang);
                  res.angle     = ang[ANGLE_BITS-1:0];
                  res.end_x     = x_raw;
                  res.end_y     = y_raw;
                  res.horiz_req = (res.dir == DIR_RIGHT || res.dir == DIR_LEFT);
                  anchor_x = x;
                  anchor_y = y;
               end
            end
            FUNC_RELEASE: begin
               pressed  = 1'b0;
               anchor_x = press_x;
               anchor_y = press_y;
               res.code = beyond_click(x - press_x, y - press_y) ? CODE_FINISH : CODE_CANCEL;
            end
            default: begin
            end
         endcase
         expected_results.push_back(res);
      endfunction

      function void compare_field(string name, logic signed [31:0] want,
                                  logic signed [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_response(swipe_result_type got);
         swipe_result_type want;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t unexpected result, code %0d dir %0d", $time, got.code, got.dir);
         end else begin
            want = expected_results.pop_front();
            compare_field("result_code", want.code, got.code);
            compare_field("swipe_dir", want.dir, got.dir);
            compare_field("angle_deg", want.angle, got.angle);
            compare_field("end_x", $signed(want.end_x), $signed(got.end_x));
            compare_field("end_y", $signed(want.end_y), $signed(got.end_y));
            compare_field("vert_script_req", want.vert_req, got.vert_req);
            compare_field("horiz_script_req", want.horiz_req, got.horiz_req);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   sgr_req_if req_bus ();
   sgr_rsp_if rsp_bus ();

   swipe_gesture_recognizer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   gesture_scoreboard board = new();
   swipe_result_type  seen_result;
   bit                hold_off = 1'b0;
   int unsigned       burst_left = 0;
   int unsigned       cur_min_dist = MIN_DISTANCE_RST;
   int unsigned       idle_cycles = 0;

   assign seen_result = {rsp_bus.result_code, rsp_bus.swipe_dir, rsp_bus.angle_deg,
                         rsp_bus.end_x, rsp_bus.end_y, rsp_bus.vert_script_req,
                         rsp_bus.horiz_script_req};

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         board.note_request(req_bus.func, req_bus.pos_x, req_bus.pos_y);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         board.check_response(seen_result);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // response side stalls on a pattern of its own
   initial begin
      int unsigned rx_mode, rx_left;
      rx_mode = 0;
      rx_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            if (rx_left == 0) begin
               rx_mode = $urandom_range(0, 3);
               rx_left = $urandom_range(16, 96);
            end
            rx_left--;
            case (rx_mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= ((rx_left % 5) < 2);
            endcase
         end
      end
   end

   task automatic send_event(func_type kind, logic [CW-1:0] x, logic [CW-1:0] y);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            req_bus.func  <= func_type'($urandom_range(0, 3));
            req_bus.pos_x <= CW'($urandom);
            req_bus.pos_y <= CW'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.func  <= kind;
      req_bus.pos_x <= x;
      req_bus.pos_y <= y;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic finish_phase();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(logic [CSR_DATA_BITS-1:0] md_data,
                             logic [CSR_DATA_BITS-1:0] tol_data);
      csr_we    <= 1'b1;
      csr_index <= REG_MIN_DISTANCE;
      csr_wdata <= md_data;
      @(posedge clock);
      csr_index <= REG_DIR_TOL;
      csr_wdata <= tol_data;
      @(posedge clock);
      csr_we    <= 1'b0;
      csr_wdata <= CSR_DATA_BITS'($urandom);
      board.write_reg(REG_MIN_DISTANCE, md_data);
      board.write_reg(REG_DIR_TOL, tol_data);
      cur_min_dist = md_data;
   endtask

   function automatic logic [CW-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return {1'b1, {(CW-1){1'b0}}};
         1: return {1'b0, {(CW-1){1'b1}}};
         2: return '0;
         default: return CW'($urandom);
      endcase
   endfunction

   function automatic logic [CW-1:0] rand_delta();
      int span;
      case ($urandom_range(0, 9))
         0: return '0;
         1, 2, 3, 4: span = cur_min_dist + 3;
         5, 6, 7, 8: span = 400;
         default: return CW'($urandom);
      endcase
      return CW'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   task automatic run_gestures(int unsigned count);
      int unsigned sent, moves;
      logic [CW-1:0] x, y, px, py, dx, dy;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) begin
            send_event(func_type'($urandom_range(0, 3)), rand_coord(), rand_coord());
            sent++;
         end else begin
            px = rand_coord();
            py = rand_coord();
            x  = px;
            y  = py;
            send_event(FUNC_PRESS, px, py);
            sent++;
            moves = $urandom_range(0, 10);
            repeat (moves) begin
               dx = rand_delta();
               dy = rand_delta();
               case ($urandom_range(0, 5))
                  0: dx = '0;
                  1: dy = '0;
                  default: ;
               endcase
               x = x + dx;
               y = y + dy;
               send_event(FUNC_MOVE, x, y);
               sent++;
            end
            if ($urandom_range(0, 7) != 0) begin
               send_event(FUNC_RELEASE, px + rand_delta(), py + rand_delta());
               sent++;
            end
         end
      end
   endtask

   task automatic run_phase(logic [CSR_DATA_BITS-1:0] md_data,
                            logic [CSR_DATA_BITS-1:0] tol_data, int unsigned count);
      finish_phase();
      write_regs(md_data, tol_data);
      run_gestures(count);
   endtask

   initial begin
      reset         <= 1'b1;
      csr_we        <= 1'b0;
      csr_index     <= REG_MIN_DISTANCE;
      csr_wdata     <= '0;
      req_bus.valid <= 1'b0;
      req_bus.func  <= FUNC_PRESS;
      req_bus.pos_x <= '0;
      req_bus.pos_y <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // release before any press, spare event kind, move while not pressed
      send_event(FUNC_RELEASE, 16'sd0, 16'sd0);
      send_event(FUNC_RELEASE, -16'sd32768, 16'sd32767);
      send_event(FUNC_SPARE, 16'sd1234, -16'sd1234);
      send_event(FUNC_MOVE, 16'sd100, 16'sd100);
      // corner to corner
      send_event(FUNC_PRESS, -16'sd32768, -16'sd32768);
      send_event(FUNC_MOVE, -16'sd32763, -16'sd32763);
      send_event(FUNC_MOVE, 16'sd32767, 16'sd32767);
      // the four sectors, the diagonal and the strict sector edge
      send_event(FUNC_PRESS, 16'sd0, 16'sd0);
      send_event(FUNC_MOVE, 16'sd100, 16'sd0);
      send_event(FUNC_MOVE, 16'sd0, 16'sd0);
      send_event(FUNC_MOVE, 16'sd0, -16'sd100);
      send_event(FUNC_MOVE, 16'sd0, 16'sd0);
      send_event(FUNC_MOVE, 16'sd100, -16'sd100);
      send_event(FUNC_MOVE, 16'sd1100, -16'sd464);
      send_event(FUNC_MOVE, 16'sd2100, -16'sd807);
      send_event(FUNC_RELEASE, 16'sd5, 16'sd5);
      send_event(FUNC_PRESS, 16'sd32767, 16'sd32767);
      send_event(FUNC_MOVE, -16'sd32768, -16'sd32768);
      send_event(FUNC_MOVE, -16'sd32768, -16'sd32759);
      send_event(FUNC_MOVE, -16'sd32758, -16'sd32768);
      send_event(FUNC_RELEASE, 16'sd32758, 16'sd32767);
      send_event(FUNC_PRESS, 16'sd1, -16'sd1);
      send_event(FUNC_RELEASE, 16'sd1, -16'sd11);
      run_gestures(200);

      // long response stall while requests keep coming
      finish_phase();
      write_regs(8'd1, 8'd1);
      hold_off = 1'b1;
      run_gestures(200);

      run_phase(8'd255, 8'd45, 200);

      // zero threshold: a move onto the anchor still scrolls
      finish_phase();
      write_regs(8'd0, 8'd63);
      send_event(FUNC_PRESS, 16'sd5, 16'sd5);
      send_event(FUNC_MOVE, 16'sd5, 16'sd5);
      run_gestures(200);

      run_phase(8'd128, 8'hC0, 150);
      repeat (3) begin
         run_phase(CSR_DATA_BITS'($urandom), CSR_DATA_BITS'($urandom), 180);
      end

      finish_phase();
      if (board.errors == 0 && board.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

/* swipe_gesture_recognizer.f */
+incdir+hdl
hdl/sgr_pkg.sv
hdl/sgr_req_if.sv
hdl/sgr_rsp_if.sv
hdl/swipe_gesture_recognizer.sv
bench/tb.sv
